### hw/rtl/sccb_pkg.sv
package sccb_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CMP_WIDTH   = 33;

   localparam logic [CMP_WIDTH-1:0] TIMER_LIMIT = CMP_WIDTH'((64'd1 << TIMER_WIDTH) - 64'd1);

   localparam logic [7:0] DEVICE_ID_RESET   = 8'd66;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
   localparam logic [7:0] READ_BIT          = 8'h01;
   localparam logic [7:0] MSB_MASK          = 8'h80;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   localparam logic REG_DEVICE_ID   = 1'b0;
   localparam logic REG_HALF_PERIOD = 1'b1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef logic [TIMER_WIDTH-1:0] timer_type;

   typedef struct packed {
      logic       cmd_valid;
      logic       func;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       nack_error;
      logic [7:0] rd_data;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  device_id;
      logic [15:0] half_period_ticks;
   } cfg_type;

endpackage

### hw/rtl/sccb_csr.sv
module sccb_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output sccb_pkg::cfg_type   cfg
);
   import sccb_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id         <= DEVICE_ID_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_DEVICE_ID:   cfg_ff.device_id <= pwdata[7:0];
            REG_HALF_PERIOD: cfg_ff.half_period_ticks <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DEVICE_ID:   prdata = {24'd0, cfg_ff.device_id};
         REG_HALF_PERIOD: prdata = {16'd0, cfg_ff.half_period_ticks};
         default:         prdata = 32'd0;
      endcase
   end

endmodule

### hw/rtl/sccb_seq.sv
module sccb_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  sccb_pkg::req_type item,
   input  sccb_pkg::cfg_type cfg,
   output sccb_pkg::rsp_type result
);
   import sccb_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_START1, PH_START2, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
      PH_ACK_HIGH, PH_GAP, PH_STOP1, PH_STOP2, PH_STOP3, PH_STOP_GAP,
      PH_RBIT_LOW, PH_RBIT_HIGH, PH_NA1, PH_NA2, PH_NA3, PH_NA4
   } phase_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic en;
   } pins_type;

   typedef struct packed {
      logic       func;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
   } held_type;

   phase_type  step_ff, step_in, a_step;
   timer_type  timer_ff, timer_in, a_timer;
   logic [3:0] bit_ff, bit_in, a_bit;
   logic [1:0] byte_ff, byte_in, a_byte;
   logic [7:0] shift_ff, shift_in;
   pins_type   pins_ff, pins_in, a_pins;
   logic       err_ff, err_in, a_err;
   logic [7:0] read_ff, read_in;
   held_type   held_ff, held_in, a_held;

   logic                 cmd, busy, done, phase_end, rd;
   logic [CMP_WIDTH-1:0] eff;

   function automatic pins_type enter_pins(phase_type ph, pins_type p, logic msb);
      pins_type r;
      r = p;
      case (ph)
         PH_START1:    r = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
         PH_START2:    r.sda = 1'b0;
         PH_BIT_LOW:   begin r.scl = 1'b0; r.en = 1'b1; r.sda = msb; end
         PH_BIT_HIGH:  r.scl = 1'b1;
         PH_ACK_LOW:   begin r.scl = 1'b0; r.en = 1'b0; end
         PH_ACK_HIGH:  r.scl = 1'b1;
         PH_GAP:       begin r.scl = 1'b0; r.en = 1'b1; end
         PH_STOP1:     r = '{scl: 1'b0, sda: 1'b0, en: 1'b1};
         PH_STOP2:     r.scl = 1'b1;
         PH_STOP3:     r.sda = 1'b1;
         PH_RBIT_LOW:  begin r.scl = 1'b0; r.en = 1'b0; end
         PH_RBIT_HIGH: r.scl = 1'b1;
         PH_NA1:       begin r.scl = 1'b0; r.en = 1'b1; end
         PH_NA2:       begin r.sda = 1'b1; r.scl = 1'b1; end
         PH_NA3:       r.scl = 1'b0;
         PH_NA4:       r.sda = 1'b0;
         default:      r = p;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] byte_to_send(logic [1:0] idx, held_type h,
                                               logic [7:0] dev);
      logic [7:0] r;
      case (idx)
         2'd0:    r = dev;
         2'd1:    r = h.reg_addr;
         default: r = (h.func == FUNC_WRITE) ? h.wr_data : (dev | READ_BIT);
      endcase
      return r;
   endfunction

   // command takes effect before the pins of this beat are shown
   always_comb begin
      cmd     = (step_ff == PH_IDLE) && item.cmd_valid;
      a_step  = cmd ? PH_START1 : step_ff;
      a_pins  = cmd ? pins_type'{scl: 1'b1, sda: 1'b1, en: 1'b1} : pins_ff;
      a_held  = cmd ? held_type'{func: item.func, reg_addr: item.reg_addr,
                                 wr_data: item.wr_data}
                    : held_ff;
      a_err   = cmd ? 1'b0 : err_ff;
      a_byte  = cmd ? 2'd0 : byte_ff;
      a_bit   = cmd ? 4'd0 : bit_ff;
      a_timer = cmd ? '0 : timer_ff;
   end

   always_comb begin
      eff = CMP_WIDTH'(cfg.half_period_ticks);
      if (cfg.half_period_ticks == 16'd0) begin
         eff = CMP_WIDTH'(1);
      end
      if (eff > TIMER_LIMIT) begin
         eff = TIMER_LIMIT;
      end
   end

   assign rd        = (a_held.func == FUNC_READ);
   assign busy      = (a_step != PH_IDLE);
   assign phase_end = (CMP_WIDTH'(a_timer) + CMP_WIDTH'(1)) >= eff;

   always_comb begin
      step_in  = a_step;
      timer_in = a_timer;
      bit_in   = a_bit;
      byte_in  = a_byte;
      shift_in = shift_ff;
      pins_in  = a_pins;
      err_in   = a_err;
      read_in  = read_ff;
      held_in  = a_held;
      done     = 1'b0;
      if (busy && !phase_end) begin
         timer_in = a_timer + timer_type'(1);
      end else if (busy) begin
         case (a_step)
            PH_START1: step_in = PH_START2;
            PH_START2: begin
               shift_in = byte_to_send(a_byte, a_held, cfg.device_id);
               bit_in   = 4'd0;
               step_in  = PH_BIT_LOW;
            end
            PH_BIT_LOW: step_in = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = a_bit + 4'd1;
               step_in  = (bit_in < BITS_PER_BYTE) ? PH_BIT_LOW : PH_ACK_LOW;
            end
            PH_ACK_LOW: step_in = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
               if (!rd && item.sda_in) begin
                  err_in = 1'b1;
               end
               step_in = (!rd && a_byte >= 2'd2) ? PH_STOP1 : PH_GAP;
            end
            PH_GAP: begin
               if (rd && a_byte == 2'd1) begin
                  step_in = PH_STOP1;
               end else if (rd && a_byte >= 2'd2) begin
                  byte_in  = 2'd3;
                  bit_in   = 4'd0;
                  shift_in = 8'd0;
                  step_in  = PH_RBIT_LOW;
               end else begin
                  byte_in  = a_byte + 2'd1;
                  shift_in = byte_to_send(byte_in, a_held, cfg.device_id);
                  bit_in   = 4'd0;
                  step_in  = PH_BIT_LOW;
               end
            end
            PH_STOP1: step_in = PH_STOP2;
            PH_STOP2: step_in = PH_STOP3;
            PH_STOP3: begin
               if (rd && a_byte == 2'd1) begin
                  step_in = PH_STOP_GAP;
               end else begin
                  step_in = PH_IDLE;
                  done    = 1'b1;
               end
            end
            PH_STOP_GAP: begin
               byte_in = 2'd2;
               step_in = PH_START1;
            end
            PH_RBIT_LOW: step_in = PH_RBIT_HIGH;
            PH_RBIT_HIGH: begin
               shift_in = {shift_ff[6:0], item.sda_in};
               bit_in   = a_bit + 4'd1;
               if (bit_in < BITS_PER_BYTE) begin
                  step_in = PH_RBIT_LOW;
               end else begin
                  read_in = shift_in;
                  step_in = PH_NA1;
               end
            end
            PH_NA1: step_in = PH_NA2;
            PH_NA2: step_in = PH_NA3;
            PH_NA3: step_in = PH_NA4;
            PH_NA4: step_in = PH_STOP1;
            default: begin
               step_in = PH_IDLE;
               done    = 1'b1;
            end
         endcase
         timer_in = '0;
         pins_in  = enter_pins(step_in, a_pins, (shift_in & MSB_MASK) != 8'd0);
      end
   end

   always_comb begin
      result.scl_out    = a_pins.scl;
      result.sda_out    = a_pins.sda;
      result.sda_drive  = a_pins.en;
      result.busy_res   = busy;
      result.done_res   = done;
      result.nack_error = err_in;
      result.rd_data    = read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= 4'd0;
         byte_ff  <= 2'd0;
         shift_ff <= 8'd0;
         pins_ff  <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
         err_ff   <= 1'b0;
         read_ff  <= 8'd0;
         held_ff  <= '0;
      end else if (advance) begin
         step_ff  <= step_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         pins_ff  <= pins_in;
         err_ff   <= err_in;
         read_ff  <= read_in;
         held_ff  <= held_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> step_ff == PH_IDLE)
      else $error("sequencer not idle after final stop");

   a_release_phases: assert property (@(posedge clock) disable iff (reset)
      !pins_ff.en |-> (step_ff == PH_ACK_LOW || step_ff == PH_ACK_HIGH ||
                       step_ff == PH_RBIT_LOW || step_ff == PH_RBIT_HIGH))
      else $error("sda released outside acknowledge or read bit");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BITS_PER_BYTE)
      else $error("bit count beyond one byte");

   a_nack_write_only: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> held_ff.func == FUNC_WRITE)
      else $error("nack flagged on a read");

endmodule

### hw/rtl/sccb_register_master.sv
// channel | ports                                  | beat
// req     | req_valid, req_stall, req_data         | one bus tick with sda sample and command
// rsp     | rsp_valid, rsp_stall, rsp_data         | pin levels and status for that tick
// csr     | psel, penable, pwrite, paddr, pwdata,  | device_id at 0, half_period_ticks at 4
//         | prdata, pready                         |
//
// one beat per cycle while rsp is not stalled; each req beat gives one rsp beat,
// registered in the input register and then in the result register around the sequencer
// reset puts the bus lines high with sda driven and the sequencer idle
// a stall on rsp holds the result register and the input register in the same cycle;
// req is taken again in the cycle the stall drops

module sccb_register_master (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sccb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sccb_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import sccb_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance, take;
   rsp_type result;
   cfg_type cfg;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_valid_in = take ? 1'b1 : (req_valid_ff && !advance);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   sccb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sccb_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

### sim/tb_sccb_register_master.sv
`timescale 1ns / 100ps

module tb_sccb_register_master;
   import sccb_pkg::*;

   localparam logic [2:0] ADDR_DEVICE_ID   = {REG_DEVICE_ID, 2'b00};
   localparam logic [2:0] ADDR_HALF_PERIOD = {REG_HALF_PERIOD, 2'b00};
   localparam int RANDOM_TICKS = 100;
   localparam int LONG_HOLD    = 300;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_START1, SEQ_START2, SEQ_BIT_LOW, SEQ_BIT_HIGH, SEQ_ACK_LOW,
      SEQ_ACK_HIGH, SEQ_GAP, SEQ_STOP1, SEQ_STOP2, SEQ_STOP3, SEQ_STOP_GAP,
      SEQ_RBIT_LOW, SEQ_RBIT_HIGH, SEQ_NA1, SEQ_NA2, SEQ_NA3, SEQ_NA4
   } seq_step_type;

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM, SDA_MOSTLY_LOW} sda_policy_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // bus sequencer shadow
   logic [7:0]   cfg_device_id;
   logic [15:0]  cfg_half_period;
   seq_step_type seq_now;
   logic [15:0]  phase_cnt;
   logic [3:0]   bit_cnt;
   logic [2:0]   byte_sel;
   logic [7:0]   shift_q;
   logic         scl_q, sda_q, sda_en_q, nack_seen;
   logic [7:0]   read_q;
   logic         held_func;
   logic [7:0]   held_reg, held_data;

   rsp_type        expected_bus[$];
   rsp_type        last_result;
   int             fail_count = 0;
   int             ticks_sent = 0;
   int             burst_left = 0;
   logic           sender_gaps = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   logic           hold_start = 1'b0;

   sccb_register_master DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void enter_phase(input seq_step_type ph);
      seq_now = ph;
      phase_cnt = '0;
      case (ph)
         SEQ_START1: begin
            sda_q = 1'b1; scl_q = 1'b1; sda_en_q = 1'b1;
         end
         SEQ_START2: sda_q = 1'b0;
         SEQ_BIT_LOW: begin
            scl_q = 1'b0; sda_en_q = 1'b1;
            sda_q = (shift_q & MSB_MASK) != 8'h00;
         end
         SEQ_BIT_HIGH, SEQ_ACK_HIGH, SEQ_STOP2, SEQ_RBIT_HIGH: scl_q = 1'b1;
         SEQ_ACK_LOW, SEQ_RBIT_LOW: begin
            scl_q = 1'b0; sda_en_q = 1'b0;
         end
         SEQ_GAP, SEQ_NA1: begin
            scl_q = 1'b0; sda_en_q = 1'b1;
         end
         SEQ_STOP1: begin
            scl_q = 1'b0; sda_en_q = 1'b1; sda_q = 1'b0;
         end
         SEQ_STOP3: sda_q = 1'b1;
         SEQ_NA2: begin
            sda_q = 1'b1; scl_q = 1'b1;
         end
         SEQ_NA3: scl_q = 1'b0;
         SEQ_NA4: sda_q = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void load_tx_byte();
      case (byte_sel)
         3'd0: shift_q = cfg_device_id;
         3'd1: shift_q = held_reg;
         default: shift_q = (held_func == FUNC_WRITE) ? held_data : (cfg_device_id | READ_BIT);
      endcase
      bit_cnt = '0;
      enter_phase(SEQ_BIT_LOW);
   endfunction

   function automatic logic end_phase(input logic sda);
      logic rd;
      logic finished;
      rd = (held_func == FUNC_READ);
      finished = 1'b0;
      case (seq_now)
         SEQ_START1:  enter_phase(SEQ_START2);
         SEQ_START2:  load_tx_byte();
         SEQ_BIT_LOW: enter_phase(SEQ_BIT_HIGH);
         SEQ_BIT_HIGH: begin
            shift_q = shift_q << 1;
            bit_cnt = bit_cnt + 4'd1;
            enter_phase(bit_cnt < BITS_PER_BYTE ? SEQ_BIT_LOW : SEQ_ACK_LOW);
         end
         SEQ_ACK_LOW: enter_phase(SEQ_ACK_HIGH);
         SEQ_ACK_HIGH: begin
            if (!rd && sda) nack_seen = 1'b1;
            enter_phase((!rd && byte_sel >= 3'd2) ? SEQ_STOP1 : SEQ_GAP);
         end
         SEQ_GAP: begin
            if (rd && byte_sel == 3'd1) begin
               enter_phase(SEQ_STOP1);
            end else if (rd && byte_sel >= 3'd2) begin
               byte_sel = 3'd3;
               bit_cnt = '0;
               shift_q = '0;
               enter_phase(SEQ_RBIT_LOW);
            end else begin
               byte_sel = byte_sel + 3'd1;
               load_tx_byte();
            end
         end
         SEQ_STOP1: enter_phase(SEQ_STOP2);
         SEQ_STOP2: enter_phase(SEQ_STOP3);
         SEQ_STOP3: begin
            if (rd && byte_sel == 3'd1) begin
               enter_phase(SEQ_STOP_GAP);
            end else begin
               seq_now = SEQ_IDLE;
               phase_cnt = '0;
               finished = 1'b1;
            end
         end
         SEQ_STOP_GAP: begin
            byte_sel = 3'd2;
            enter_phase(SEQ_START1);
         end
         SEQ_RBIT_LOW: enter_phase(SEQ_RBIT_HIGH);
         SEQ_RBIT_HIGH: begin
            shift_q = {shift_q[6:0], sda};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) begin
               enter_phase(SEQ_RBIT_LOW);
            end else begin
               read_q = shift_q;
               enter_phase(SEQ_NA1);
            end
         end
         SEQ_NA1: enter_phase(SEQ_NA2);
         SEQ_NA2: enter_phase(SEQ_NA3);
         SEQ_NA3: enter_phase(SEQ_NA4);
         SEQ_NA4: enter_phase(SEQ_STOP1);
         default: begin
            seq_now = SEQ_IDLE;
            phase_cnt = '0;
            finished = 1'b1;
         end
      endcase
      return finished;
   endfunction

   function automatic rsp_type bus_tick(input req_type r);
      rsp_type o;
      int eff;
      logic finished;
      eff = (cfg_half_period == 16'd0) ? 1 : int'(cfg_half_period);
      finished = 1'b0;
      if (seq_now == SEQ_IDLE && r.cmd_valid) begin
         held_func = r.func;
         held_reg = r.reg_addr;
         held_data = r.wr_data;
         nack_seen = 1'b0;
         byte_sel = '0;
         bit_cnt = '0;
         enter_phase(SEQ_START1);
      end
      o.scl_out = scl_q;
      o.sda_out = sda_q;
      o.sda_drive = sda_en_q;
      o.busy_res = (seq_now != SEQ_IDLE);
      if (seq_now != SEQ_IDLE) begin
         if (int'(phase_cnt) + 1 >= eff) finished = end_phase(r.sda_in);
         else phase_cnt = phase_cnt + 16'd1;
      end
      o.done_res = finished;
      o.nack_error = nack_seen;
      o.rd_data = read_q;
      return o;
   endfunction

   task automatic reset_shadow();
      cfg_device_id = DEVICE_ID_RESET;
      cfg_half_period = HALF_PERIOD_RESET;
      seq_now = SEQ_IDLE;
      phase_cnt = '0;
      bit_cnt = '0;
      byte_sel = '0;
      shift_q = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      sda_en_q = 1'b1;
      nack_seen = 1'b0;
      read_q = '0;
      held_func = FUNC_WRITE;
      held_reg = '0;
      held_data = '0;
      last_result = '0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // result checker
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_bus.size() == 0) begin
               report_mismatch("rsp beat with nothing expected");
            end else begin
               want = expected_bus.pop_front();
               compare_field("scl_out", 8'(rsp_data.scl_out), 8'(want.scl_out));
               compare_field("sda_out", 8'(rsp_data.sda_out), 8'(want.sda_out));
               compare_field("sda_drive", 8'(rsp_data.sda_drive), 8'(want.sda_drive));
               compare_field("busy_res", 8'(rsp_data.busy_res), 8'(want.busy_res));
               compare_field("done_res", 8'(rsp_data.done_res), 8'(want.done_res));
               compare_field("nack_error", 8'(rsp_data.nack_error),
                             8'(want.nack_error));
               compare_field("rd_data", rsp_data.rd_data, want.rd_data);
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      int hold_left;
      int stall_tick;
      hold_left = 0;
      stall_tick = 0;
      forever begin
         @(posedge clock);
         stall_tick++;
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:      rsp_stall <= (stall_tick % 11) < 4;
            endcase
         end
      end
   end

   task automatic send_tick(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      last_result = bus_tick(beat);
      expected_bus.push_back(last_result);
      ticks_sent++;
   endtask

   function automatic logic pick_sda(input sda_policy_type pol);
      case (pol)
         SDA_LOW:    return 1'b0;
         SDA_HIGH:   return 1'b1;
         SDA_RANDOM: return 1'($urandom_range(0, 1));
         default:    return $urandom_range(0, 7) == 0;
      endcase
   endfunction

   task automatic send_idle_ticks(input int n, input sda_policy_type pol);
      req_type beat;
      repeat (n) begin
         beat = req_type'($urandom);
         beat.cmd_valid = 1'b0;
         beat.sda_in = pick_sda(pol);
         send_tick(beat);
      end
   endtask

   task automatic tick_until_done(input sda_policy_type pol, input logic noisy);
      req_type beat;
      while (!last_result.done_res) begin
         beat = req_type'($urandom);
         beat.cmd_valid = noisy && ($urandom_range(0, 5) == 0);
         beat.sda_in = pick_sda(pol);
         send_tick(beat);
      end
   endtask

   task automatic run_transfer(input logic func, input logic [7:0] reg_addr,
                               input logic [7:0] wr_data, input sda_policy_type pol,
                               input logic noisy);
      req_type beat;
      beat.cmd_valid = 1'b1;
      beat.func = func;
      beat.reg_addr = reg_addr;
      beat.wr_data = wr_data;
      beat.sda_in = pick_sda(pol);
      send_tick(beat);
      tick_until_done(pol, noisy);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bus.size() != 0);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr[2] == REG_HALF_PERIOD) begin
         cfg_half_period = value[15:0];
         want = {16'h0, value[15:0]};
      end else begin
         cfg_device_id = value[7:0];
         want = {24'h0, value[7:0]};
      end
      @(posedge clock);
      if (prdata !== want)
         report_mismatch($sformatf("csr readback got %0h expected %0h", prdata, want));
   endtask

   task automatic configure(input logic [7:0] dev, input logic [15:0] half);
      drain_results();
      write_csr(ADDR_DEVICE_ID, {24'h0, dev});
      write_csr(ADDR_HALF_PERIOD, {16'h0, half});
   endtask

   task automatic test_reset_state();
      req_type beat;
      stall_mode = STALL_NONE;
      sender_gaps = 1'b0;
      send_idle_ticks(8, SDA_RANDOM);
      // reset timing and address: run partway into the first byte
      beat = '0;
      beat.cmd_valid = 1'b1;
      beat.func = FUNC_WRITE;
      beat.reg_addr = 8'h3C;
      beat.wr_data = 8'hC3;
      send_tick(beat);
      send_idle_ticks(110, SDA_LOW);
      configure(DEVICE_ID_RESET, 16'd1);
      tick_until_done(SDA_LOW, 1'b0);
      drain_results();
   endtask

   task automatic run_partial(input logic func, input int n);
      req_type beat;
      beat = req_type'($urandom);
      beat.cmd_valid = 1'b1;
      beat.func = func;
      send_tick(beat);
      send_idle_ticks(n, SDA_MOSTLY_LOW);
   endtask

   task automatic test_directed_transfers();
      stall_mode = STALL_RANDOM;
      sender_gaps = 1'b1;
      configure(DEVICE_ID_RESET, 16'd1);
      run_transfer(FUNC_WRITE, 8'h00, 8'h00, SDA_LOW, 1'b0);
      run_transfer(FUNC_WRITE, 8'hFF, 8'hFF, SDA_HIGH, 1'b0);
      run_transfer(FUNC_READ, 8'hA5, 8'h00, SDA_HIGH, 1'b0);
      run_transfer(FUNC_READ, 8'h5A, 8'hFF, SDA_LOW, 1'b0);
      run_transfer(FUNC_WRITE, 8'h81, 8'h7E, SDA_MOSTLY_LOW, 1'b1);
      configure(8'd0, 16'd1);
      run_transfer(FUNC_READ, 8'h12, 8'h34, SDA_RANDOM, 1'b1);
      configure(8'd254, 16'd2);
      run_transfer(FUNC_WRITE, 8'h56, 8'h78, SDA_RANDOM, 1'b0);
      run_transfer(FUNC_READ, 8'h9A, 8'hBC, SDA_RANDOM, 1'b0);
      drain_results();
   endtask

   task automatic test_half_period_limits();
      stall_mode = STALL_PATTERN;
      configure(8'h60, 16'd0);
      run_transfer(FUNC_WRITE, 8'hE1, 8'h1E, SDA_MOSTLY_LOW, 1'b0);
      run_transfer(FUNC_READ, 8'h1E, 8'hE1, SDA_RANDOM, 1'b0);
      configure(8'h61, 16'hFFFF);
      run_partial(FUNC_WRITE, 20);
      configure(8'h61, 16'd3);
      tick_until_done(SDA_MOSTLY_LOW, 1'b0);
      configure(8'h62, 16'hFFFF);
      run_partial(FUNC_READ, 20);
      configure(8'h62, 16'd1);
      tick_until_done(SDA_RANDOM, 1'b0);
      drain_results();
   endtask

   task automatic test_backpressure();
      configure(8'h42, 16'd1);
      stall_mode = STALL_NONE;
      sender_gaps = 1'b0;
      hold_start = 1'b1;
      run_transfer(FUNC_READ, 8'h77, 8'h00, SDA_RANDOM, 1'b1);
      run_transfer(FUNC_WRITE, 8'h88, 8'h99, SDA_MOSTLY_LOW, 1'b1);
      // sender waits here for every outstanding beat
      drain_results();
   endtask

   task automatic test_random_traffic();
      int target;
      int pick;
      logic [15:0] half;
      target = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < target) begin
         pick = $urandom_range(0, 99);
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (pick < 12) begin
            pick = $urandom_range(0, 9);
            half = (pick < 4) ? 16'($urandom_range(0, 1)) :
                   (pick < 7) ? 16'd2 :
                   (pick < 9) ? 16'($urandom_range(3, 4)) : 16'($urandom_range(5, 9));
            configure(8'($urandom_range(0, 254)), half);
         end else if (pick < 17) begin
            send_idle_ticks($urandom_range(1, 20), SDA_RANDOM);
         end else begin
            run_transfer(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                         sda_policy_type'($urandom_range(0, 3)),
                         ($urandom_range(0, 2) == 0));
         end
      end
      drain_results();
   endtask

   initial begin
      reset_shadow();
      do @(posedge clock); while (reset);
      test_reset_state();
      test_directed_transfers();
      test_half_period_limits();
      test_backpressure();
      test_random_traffic();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
